// ===== rtl/core/aqp_pkg.sv =====
package aqp_pkg;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_Q     = 8'h71;

  localparam logic [9:0] FULL_WEIGHT = 10'd1000;
  localparam logic [1:0] MAX_FRAC    = 2'd3;

  typedef enum logic [3:0] {
    PH_NOT_STARTED,
    PH_VALUE,
    PH_VALUE_SPACES,
    PH_SEMI,
    PH_Q_SEEN,
    PH_EQ_SEEN,
    PH_PRE_WEIGHT,
    PH_WEIGHT,
    PH_POST_WEIGHT,
    PH_END,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_ELEM,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [9:0] accum;
    logic       point_seen;
    logic [1:0] frac_digits;
    logic       digit_seen;
  } weight_st_t;

  localparam weight_st_t WEIGHT_CLEAR = '{accum: 10'd0, point_seen: 1'b0,
                                          frac_digits: 2'd0, digit_seen: 1'b0};

  typedef struct packed {
    phase_t     phase;
    weight_st_t wt;
  } parse_st_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value_byte;
    logic [9:0] weight;
    logic       list_done;
  } result_t;

  // Place value of the next fraction digit, in thousandths.
  function automatic logic [6:0] frac_scale(input logic [1:0] idx);
    logic [6:0] s;
    case (idx)
      2'd0:    s = 7'd100;
      2'd1:    s = 7'd10;
      default: s = 7'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/accept_header_qvalue_parser.sv =====
// Channel   Ports                                          Direction
// input     in_valid, in_ready, in_byte_in                 one header byte per word, in
// result    out_valid, out_ready, out_kind, out_value_byte,
//           out_weight, out_list_done                      zero or one word per byte, out
//
// One byte per clock is sustained while the output is not stalled. A byte is held in the input
// register, where the parse step runs, and its result word is loaded into the output
// register when the byte is consumed, which a stalled output can hold back.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the start of a list. A stalled output only holds the input register when
// the byte there would produce a word; bytes that produce nothing keep flowing.
module accept_header_qvalue_parser
  import aqp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value_byte,
  output logic [9:0] out_weight,
  output logic       out_list_done
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  parse_st_t  st_r;
  parse_st_t  st_nxt;
  logic       out_valid_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       emit;
  logic       out_free;
  logic       consume;

  aqp_step u_step (
    .char_in (in_byte_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .emit    (emit),
    .res     (res_nxt)
  );

  assign out_free = !out_valid_r || out_ready;
  assign consume  = in_valid_r && (!emit || out_free);
  assign in_ready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_NOT_STARTED, wt: WEIGHT_CLEAR};
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (consume) st_r <= st_nxt;
      if (consume && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_byte_r <= in_byte_in;
    if (consume && emit) res_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_value_byte = res_r.value_byte;
  assign out_weight     = res_r.weight;
  assign out_list_done  = res_r.list_done;

endmodule

// ===== rtl/core/aqp_weight.sv =====
module aqp_weight
  import aqp_pkg::*;
(
  input  logic [7:0] char_in,
  input  weight_st_t wt,
  output weight_st_t wt_nxt,
  output logic       take_ok
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [14:0] int_sum;
  logic [14:0] frac_sum;
  logic [14:0] t;

  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign digit    = 4'(char_in - CH_ZERO);
  assign int_sum  = 15'(wt.accum) * 15'd10 + 15'(digit) * 15'(FULL_WEIGHT);
  assign frac_sum = 15'(wt.accum) + 15'(digit) * 15'(frac_scale(wt.frac_digits));

  always_comb begin
    wt_nxt  = wt;
    take_ok = 1'b0;
    t       = 15'(wt.accum);
    if (is_digit) begin
      take_ok = 1'b1;
      if (!wt.point_seen) begin
        t = int_sum;
      end else if (wt.frac_digits < MAX_FRAC) begin
        // Digits past the third decimal are dropped.
        t = frac_sum;
        wt_nxt.frac_digits = wt.frac_digits + 2'd1;
      end
      wt_nxt.accum      = (t > 15'(FULL_WEIGHT)) ? FULL_WEIGHT : t[9:0];
      wt_nxt.digit_seen = 1'b1;
    end else if (char_in == CH_POINT && !wt.point_seen) begin
      take_ok           = 1'b1;
      wt_nxt.point_seen = 1'b1;
    end
  end

endmodule

// ===== rtl/core/aqp_step.sv =====
module aqp_step
  import aqp_pkg::*;
(
  input  logic [7:0] char_in,
  input  parse_st_t  st,
  output parse_st_t  st_nxt,
  output logic       emit,
  output result_t    res
);

  weight_st_t wt_take;
  logic       take_ok;
  logic       is_sep;

  aqp_weight u_weight (
    .char_in (char_in),
    .wt      (st.wt),
    .wt_nxt  (wt_take),
    .take_ok (take_ok)
  );

  assign is_sep = (char_in == CH_SPACE) || (char_in == CH_COMMA) || (char_in == CH_NUL);

  // Next parse state.
  always_comb begin
    st_nxt = st;
    case (st.phase)
      PH_NOT_STARTED, PH_VALUE, PH_VALUE_SPACES: begin
        if (char_in == CH_SPACE) begin
          if (st.phase != PH_NOT_STARTED) st_nxt.phase = PH_VALUE_SPACES;
        end else if (char_in == CH_COMMA) begin
          st_nxt = '{phase: PH_NOT_STARTED, wt: WEIGHT_CLEAR};
        end else if (char_in == CH_SEMI) begin
          st_nxt = '{phase: PH_SEMI, wt: WEIGHT_CLEAR};
        end else if (char_in == CH_NUL) begin
          st_nxt = '{phase: PH_END, wt: WEIGHT_CLEAR};
        end else begin
          st_nxt.phase = PH_VALUE;
        end
      end
      PH_SEMI: begin
        if (char_in == CH_Q) begin
          st_nxt.phase = PH_Q_SEEN;
        end else if (char_in != CH_SPACE) begin
          st_nxt = '{phase: PH_ERROR, wt: WEIGHT_CLEAR};
        end
      end
      PH_Q_SEEN: begin
        if (char_in == CH_EQUAL) begin
          st_nxt.phase = PH_EQ_SEEN;
        end else begin
          st_nxt = '{phase: PH_ERROR, wt: WEIGHT_CLEAR};
        end
      end
      PH_EQ_SEEN, PH_PRE_WEIGHT: begin
        if (char_in == CH_SPACE) begin
          st_nxt.phase = PH_PRE_WEIGHT;
        end else if (take_ok) begin
          st_nxt = '{phase: PH_WEIGHT, wt: wt_take};
        end else begin
          st_nxt = '{phase: PH_ERROR, wt: WEIGHT_CLEAR};
        end
      end
      PH_WEIGHT: begin
        if (is_sep) begin
          if (!st.wt.digit_seen) begin
            st_nxt = '{phase: PH_ERROR, wt: WEIGHT_CLEAR};
          end else if (char_in == CH_SPACE) begin
            st_nxt = '{phase: PH_POST_WEIGHT, wt: WEIGHT_CLEAR};
          end else if (char_in == CH_COMMA) begin
            st_nxt = '{phase: PH_NOT_STARTED, wt: WEIGHT_CLEAR};
          end else begin
            st_nxt = '{phase: PH_END, wt: WEIGHT_CLEAR};
          end
        end else if (take_ok) begin
          st_nxt.wt = wt_take;
        end else begin
          st_nxt = '{phase: PH_ERROR, wt: WEIGHT_CLEAR};
        end
      end
      PH_POST_WEIGHT: begin
        if (char_in == CH_COMMA) begin
          st_nxt.phase = PH_NOT_STARTED;
        end else if (char_in != CH_SPACE) begin
          st_nxt = '{phase: PH_ERROR, wt: WEIGHT_CLEAR};
        end
      end
      default: begin
        // End of list and error both swallow every byte.
        st_nxt = st;
      end
    endcase
  end

  // Result word for this byte, if any.
  always_comb begin
    emit = 1'b0;
    res  = '{kind: KIND_BYTE, value_byte: 8'd0, weight: 10'd0, list_done: 1'b0};
    case (st.phase)
      PH_NOT_STARTED, PH_VALUE, PH_VALUE_SPACES: begin
        if (char_in == CH_COMMA || char_in == CH_NUL) begin
          emit          = 1'b1;
          res.kind      = KIND_ELEM;
          res.weight    = FULL_WEIGHT;
          res.list_done = (char_in == CH_NUL);
        end else if (char_in != CH_SPACE && char_in != CH_SEMI) begin
          emit           = 1'b1;
          res.value_byte = char_in;
        end
      end
      PH_SEMI: begin
        if (char_in != CH_SPACE && char_in != CH_Q) begin
          emit     = 1'b1;
          res.kind = KIND_ERROR;
        end
      end
      PH_Q_SEEN: begin
        if (char_in != CH_EQUAL) begin
          emit     = 1'b1;
          res.kind = KIND_ERROR;
        end
      end
      PH_EQ_SEEN, PH_PRE_WEIGHT: begin
        if (char_in != CH_SPACE && !take_ok) begin
          emit     = 1'b1;
          res.kind = KIND_ERROR;
        end
      end
      PH_WEIGHT: begin
        if (is_sep) begin
          emit = 1'b1;
          if (!st.wt.digit_seen) begin
            res.kind = KIND_ERROR;
          end else begin
            res.kind      = KIND_ELEM;
            res.weight    = st.wt.accum;
            res.list_done = (char_in == CH_NUL);
          end
        end else if (!take_ok) begin
          emit     = 1'b1;
          res.kind = KIND_ERROR;
        end
      end
      PH_POST_WEIGHT: begin
        if (char_in != CH_SPACE && char_in != CH_COMMA) begin
          emit     = 1'b1;
          res.kind = KIND_ERROR;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/aqp_checker.sv =====
module aqp_checker
  import aqp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_value_byte,
  input logic [9:0] out_weight,
  input logic       out_list_done
);

  logic closed_r;
  logic in_seen_r;

  // Once an error or a list end has been delivered, the parser is silent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r  <= 1'b0;
      in_seen_r <= 1'b0;
    end else begin
      if (out_valid && out_ready &&
          (out_kind == KIND_ERROR || (out_kind == KIND_ELEM && out_list_done))) begin
        closed_r <= 1'b1;
      end
      if (in_valid && in_ready && in_byte_in == CH_NUL) in_seen_r <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_weight)
      && $stable(out_value_byte) && $stable(out_list_done))
    else $error("result word changed while stalled");

  a_silent_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> !out_valid)
    else $error("result word after error or list end");

  a_done_needs_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ELEM && out_list_done |-> in_seen_r)
    else $error("list end reported before any NUL byte was taken");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3 && out_weight <= FULL_WEIGHT)
    else $error("bad kind or weight out of range");

  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ELEM |-> out_weight == 10'd0 && !out_list_done)
    else $error("weight or list end set on a non-element word");

endmodule

bind accept_header_qvalue_parser aqp_checker u_aqp_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import aqp_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BYTES  = 1500;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [7:0] ch;
    bit         hold;
  } header_word_t;

  typedef enum int {
    END_AT_START,
    END_IN_VALUE,
    END_AFTER_SPACES,
    END_IN_WEIGHT,
    END_BAD_WEIGHT_CHAR,
    END_SECOND_POINT,
    END_EMPTY_WEIGHT,
    END_NO_Q,
    END_NO_EQUAL,
    END_AFTER_WEIGHT
  } list_end_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_value_byte;
  logic [9:0] out_weight;
  logic       out_list_done;

  accept_header_qvalue_parser uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_in    (in_byte_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_value_byte(out_value_byte),
    .out_weight    (out_weight),
    .out_list_done (out_list_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  header_word_t header_q[$];
  result_t      awaited_words[$];
  bit           hold_next = 1'b0;
  int           fail_count = 0;
  int           cycle_count = 0;

  // Mirror of the parser state.
  phase_t     parse_ph = PH_NOT_STARTED;
  logic [9:0] q_accum = 10'd0;
  logic       q_point = 1'b0;
  logic [1:0] q_frac = 2'd0;
  logic       q_digit = 1'b0;

  function automatic void clear_qvalue();
    q_accum = 10'd0;
    q_point = 1'b0;
    q_frac  = 2'd0;
    q_digit = 1'b0;
  endfunction

  function automatic bit raise_parse_error(output result_t r);
    parse_ph = PH_ERROR;
    clear_qvalue();
    r = '{kind: KIND_ERROR, value_byte: 8'd0, weight: 10'd0, list_done: 1'b0};
    return 1'b1;
  endfunction

  // Folds one weight character into the accumulator; 0 means the character is illegal.
  function automatic bit absorb_qchar(input logic [7:0] c);
    int t;
    int d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = int'(c) - int'(CH_ZERO);
      t = int'(q_accum);
      if (!q_point) begin
        t = t * 10 + d * int'(FULL_WEIGHT);
      end else if (q_frac < MAX_FRAC) begin
        case (q_frac)
          2'd0:    t = t + d * 100;
          2'd1:    t = t + d * 10;
          default: t = t + d;
        endcase
        q_frac = q_frac + 2'd1;
      end
      if (t > int'(FULL_WEIGHT)) t = int'(FULL_WEIGHT);
      q_accum = 10'(t);
      q_digit = 1'b1;
      return 1'b1;
    end
    if (c == CH_POINT && !q_point) begin
      q_point = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit next_parse_result(input logic [7:0] c, output result_t r);
    bit emit;
    r = '{kind: KIND_BYTE, value_byte: 8'd0, weight: 10'd0, list_done: 1'b0};
    emit = 1'b0;
    case (parse_ph)
      PH_NOT_STARTED, PH_VALUE, PH_VALUE_SPACES: begin
        if (c == CH_SPACE) begin
          if (parse_ph != PH_NOT_STARTED) parse_ph = PH_VALUE_SPACES;
        end else if (c == CH_COMMA || c == CH_NUL) begin
          parse_ph = (c == CH_NUL) ? PH_END : PH_NOT_STARTED;
          clear_qvalue();
          emit = 1'b1;
          r.kind = KIND_ELEM;
          r.weight = FULL_WEIGHT;
          r.list_done = (c == CH_NUL);
        end else if (c == CH_SEMI) begin
          parse_ph = PH_SEMI;
          clear_qvalue();
        end else begin
          parse_ph = PH_VALUE;
          emit = 1'b1;
          r.value_byte = c;
        end
      end
      PH_SEMI: begin
        if (c == CH_Q) parse_ph = PH_Q_SEEN;
        else if (c != CH_SPACE) emit = raise_parse_error(r);
      end
      PH_Q_SEEN: begin
        if (c == CH_EQUAL) parse_ph = PH_EQ_SEEN;
        else emit = raise_parse_error(r);
      end
      PH_EQ_SEEN, PH_PRE_WEIGHT: begin
        if (c == CH_SPACE) parse_ph = PH_PRE_WEIGHT;
        else if (absorb_qchar(c)) parse_ph = PH_WEIGHT;
        else emit = raise_parse_error(r);
      end
      PH_WEIGHT: begin
        if (c == CH_SPACE || c == CH_COMMA || c == CH_NUL) begin
          if (!q_digit) begin
            emit = raise_parse_error(r);
          end else begin
            emit = 1'b1;
            r.kind = KIND_ELEM;
            r.weight = q_accum;
            clear_qvalue();
            if (c == CH_SPACE) begin
              parse_ph = PH_POST_WEIGHT;
            end else if (c == CH_COMMA) begin
              parse_ph = PH_NOT_STARTED;
            end else begin
              parse_ph = PH_END;
              r.list_done = 1'b1;
            end
          end
        end else if (!absorb_qchar(c)) begin
          emit = raise_parse_error(r);
        end
      end
      PH_POST_WEIGHT: begin
        if (c == CH_COMMA) parse_ph = PH_NOT_STARTED;
        else if (c != CH_SPACE) emit = raise_parse_error(r);
      end
      default: ;
    endcase
    return emit;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int draw_idle(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sender.
  int send_idle = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_byte_in <= 8'h00;
      send_idle = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
        send_idle = draw_idle(send_calm);
      end
      if (send_idle > 0) begin
        send_idle--;
        in_valid <= 1'b0;
      end else if (header_q.size() > 0 &&
                   (!header_q[0].hold || (awaited_words.size() == 0 && !in_valid))) begin
        in_valid   <= 1'b1;
        in_byte_in <= header_q[0].ch;
        header_q.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: predicts on each accepted byte and checks each accepted word.
  int  recv_stall = 0;
  bit  recv_calm = 1'b0;

  always @(posedge clk) begin
    result_t want;
    bit      has_word;
    if (!rst_n) begin
      out_ready <= 1'b0;
      parse_ph = PH_NOT_STARTED;
      clear_qvalue();
    end else begin
      if (in_valid && in_ready) begin
        has_word = next_parse_result(in_byte_in, want);
        if (has_word) awaited_words.insert(awaited_words.size(), want);
      end
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          $error("word with nothing awaited: kind %0d, byte %0d, weight %0d, done %0d",
                 out_kind, out_value_byte, out_weight, out_list_done);
          fail_count++;
        end else begin
          want = awaited_words.pop_front();
          check_field("kind", 10'(want.kind), 10'(out_kind));
          check_field("value_byte", 10'(want.value_byte), 10'(out_value_byte));
          check_field("weight", want.weight, out_weight);
          check_field("list_done", 10'(want.list_done), 10'(out_list_done));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
        recv_stall = draw_idle(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("accept_header_qvalue_parser regression: fail");
      $finish;
    end
  end

  task automatic push_ch(input logic [7:0] c);
    header_word_t w;
    w.ch   = c;
    w.hold = hold_next;
    header_q.insert(header_q.size(), w);
    hold_next = 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  task automatic push_spaces(input int n);
    for (int i = 0; i < n; i++) push_ch(CH_SPACE);
  endtask

  // Value characters, with the odd space inside.
  task automatic push_value(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) push_spaces($urandom_range(1, 2));
      do c = 8'($urandom_range(1, 255));
      while (c == CH_SPACE || c == CH_COMMA || c == CH_SEMI);
      push_ch(c);
    end
  endtask

  // Weight text with at least one digit, at most one point.
  task automatic push_weight_digits();
    int n_int;
    int n_frac;
    bit pt;
    n_int  = $urandom_range(0, 2);
    pt     = $urandom_range(0, 1);
    n_frac = pt ? $urandom_range(0, 5) : 0;
    if (n_int == 0 && n_frac == 0) n_int = 1;
    for (int i = 0; i < n_int; i++) begin
      if (i == 0 && $urandom_range(0, 1)) push_ch(CH_ZERO + 8'($urandom_range(0, 1)));
      else push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (pt) push_ch(CH_POINT);
    for (int i = 0; i < n_frac; i++) push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_qvalue_head();
    push_ch(CH_SEMI);
    push_spaces($urandom_range(0, 3) == 0 ? 1 : 0);
    push_ch(CH_Q);
    push_ch(CH_EQUAL);
    push_spaces($urandom_range(0, 3) == 0 ? 1 : 0);
  endtask

  task automatic push_element();
    int n;
    push_spaces($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
    n = $urandom_range(0, 5);
    push_value(n);
    if (n > 0) push_spaces($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
    if ($urandom_range(0, 9) < 6) begin
      push_qvalue_head();
      push_weight_digits();
      if ($urandom_range(0, 2) == 0) push_spaces($urandom_range(1, 2));
    end
    push_ch(CH_COMMA);
  endtask

  // The list can end only once per run, so the way it ends is drawn at random.
  task automatic push_list_end();
    list_end_t how;
    logic [7:0] c;
    how = list_end_t'($urandom_range(0, 9));
    case (how)
      END_AT_START: push_ch(CH_NUL);
      END_IN_VALUE: begin
        push_value($urandom_range(1, 4));
        push_ch(CH_NUL);
      end
      END_AFTER_SPACES: begin
        push_value($urandom_range(1, 3));
        push_spaces($urandom_range(1, 2));
        push_ch(CH_NUL);
      end
      END_IN_WEIGHT: begin
        push_value($urandom_range(0, 3));
        push_qvalue_head();
        push_weight_digits();
        push_ch(CH_NUL);
      end
      END_BAD_WEIGHT_CHAR: begin
        push_value($urandom_range(0, 3));
        push_qvalue_head();
        if ($urandom_range(0, 1)) push_weight_digits();
        do c = 8'($urandom_range(1, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT || c == CH_SPACE ||
               c == CH_COMMA);
        push_ch(c);
      end
      END_SECOND_POINT: begin
        push_value($urandom_range(0, 3));
        push_text(";q=0.5.");
      end
      END_EMPTY_WEIGHT: begin
        push_value($urandom_range(0, 3));
        push_text(";q=.");
        case ($urandom_range(0, 2))
          0:       push_ch(CH_COMMA);
          1:       push_ch(CH_SPACE);
          default: push_ch(CH_NUL);
        endcase
      end
      END_NO_Q: begin
        push_value($urandom_range(0, 3));
        push_ch(CH_SEMI);
        push_spaces($urandom_range(0, 1));
        do c = 8'($urandom_range(0, 255));
        while (c == CH_Q || c == CH_SPACE);
        push_ch(c);
      end
      END_NO_EQUAL: begin
        push_value($urandom_range(0, 3));
        push_text(";q");
        do c = 8'($urandom_range(0, 255));
        while (c == CH_EQUAL);
        push_ch(c);
      end
      default: begin
        // A complete weight and a space, followed by something other than a space or comma.
        push_value($urandom_range(0, 3));
        push_text(";q=1 ");
        if ($urandom_range(0, 1)) begin
          push_ch(CH_NUL);
        end else begin
          do c = 8'($urandom_range(1, 255));
          while (c == CH_SPACE || c == CH_COMMA);
          push_ch(c);
        end
      end
    endcase
    // Everything after this point must be ignored.
    for (int i = $urandom_range(4, 12); i > 0; i--) push_ch(8'($urandom_range(0, 255)));
    push_ch(CH_NUL);
    push_ch(CH_COMMA);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;

    // Leading and inner spaces, empty element, spaced weight with extra decimals,
    // saturation on an element with no value.
    push_text(" a b ,");
    push_ch(CH_COMMA);
    push_ch(8'hff);
    push_text("; q= .1234 ,");
    push_text(";q=7,");

    hold_next = 1'b1;
    while (header_q.size() < RANDOM_BYTES) begin
      if (!paused && header_q.size() > RANDOM_BYTES / 2) begin
        hold_next = 1'b1;
        paused = 1'b1;
      end
      push_element();
    end
    push_list_end();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (header_q.size() != 0 || in_valid) @(negedge clk);
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (awaited_words.size() != 0) begin
      $error("%0d words never arrived", awaited_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("accept_header_qvalue_parser regression: pass");
    end else begin
      $display("accept_header_qvalue_parser regression: fail");
    end
    $finish;
  end

endmodule
